>>> rtl/core/partition_allocator_first_best_worst_fit_macros.svh
// assertion macros for the partition allocator
// used by the top level; no other dependencies
`ifndef PARTITION_ALLOCATOR_FIRST_BEST_WORST_FIT_MACROS_SVH
`define PARTITION_ALLOCATOR_FIRST_BEST_WORST_FIT_MACROS_SVH

// assertion checked every clock while out of reset
`define PA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// assertion checked every clock, during reset too
`define PA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/core/pafit_pkg.sv
// shared constants, types and functions for the partition allocator
// no dependencies
`default_nettype none
package pafit_pkg;

  localparam int unsigned MaxSegments = 32;
  localparam int unsigned AddrWidth   = 16;
  localparam int unsigned JobWidth    = 16;
  localparam int unsigned ResWidth    = 11;

  localparam logic [15:0] ReservedJob  = 16'hFFFF;
  localparam logic [15:0] MemSizeReset = 16'd5120;
  localparam logic [10:0] ResLenReset  = 11'd8;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StNoFit = 2'd1;
  localparam logic [1:0] StNoJob = 2'd2;
  localparam logic [1:0] StFull  = 2'd3;

  localparam logic [1:0] PolFirst = 2'd0;
  localparam logic [1:0] PolBest  = 2'd1;
  localparam logic [1:0] PolWorst = 2'd2;

  localparam logic RegMemSize = 1'b0;
  localparam logic RegResLen  = 1'b1;

  // commands broadcast from the sequencer to every cell
  typedef struct packed {
    logic init;
    logic shift_up;
    logic shift_dn;
    logic write_pick;
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> rtl/core/pafit_cell.sv
// one table entry of the segment chain; shifts with its neighbors
// depends on pafit_pkg
`default_nettype none
module pafit_cell #(
  parameter int unsigned AW = pafit_pkg::AddrWidth,
  parameter int unsigned IW = 5
) (
  input  wire logic                   clk_i,
  input  wire pafit_pkg::cell_ctl_t   ctl_i,
  input  wire logic [IW-1:0]          self_i,
  input  wire logic [IW-1:0]          lo_i,
  input  wire logic [IW-1:0]          hi_i,
  input  wire logic                   init_used_i,
  input  wire logic [15:0]            init_job_i,
  input  wire logic [AW-1:0]          init_start_i,
  input  wire logic [AW-1:0]          init_len_i,
  input  wire logic                   w_used_i,
  input  wire logic [15:0]            w_job_i,
  input  wire logic [AW-1:0]          w_start_i,
  input  wire logic [AW-1:0]          w_len_i,
  input  wire logic [IW-1:0]          w_idx_i,
  input  wire logic                   w2_en_i,
  input  wire logic [AW-1:0]          w2_start_i,
  input  wire logic [AW-1:0]          w2_len_i,
  input  wire logic                   prv_used_i,
  input  wire logic [15:0]            prv_job_i,
  input  wire logic [AW-1:0]          prv_start_i,
  input  wire logic [AW-1:0]          prv_len_i,
  input  wire logic                   nxt_used_i,
  input  wire logic [15:0]            nxt_job_i,
  input  wire logic [AW-1:0]          nxt_start_i,
  input  wire logic [AW-1:0]          nxt_len_i,
  output logic                        used_o,
  output logic [15:0]                 job_o,
  output logic [AW-1:0]               start_o,
  output logic [AW-1:0]               len_o
);

  logic          used_q;
  logic [15:0]   job_q;
  logic [AW-1:0] start_q, len_q;
  logic          in_rng;

  assign in_rng = (self_i > lo_i) && (self_i <= hi_i);

  always_ff @(posedge clk_i) begin
    if (ctl_i.init) begin
      used_q  <= init_used_i;
      job_q   <= init_job_i;
      start_q <= init_start_i;
      len_q   <= init_len_i;
    end else if (ctl_i.shift_up && in_rng) begin
      used_q  <= prv_used_i;
      job_q   <= prv_job_i;
      start_q <= prv_start_i;
      len_q   <= prv_len_i;
    end else if (ctl_i.shift_dn && in_rng) begin
      used_q  <= nxt_used_i;
      job_q   <= nxt_job_i;
      start_q <= nxt_start_i;
      len_q   <= nxt_len_i;
    end else if (ctl_i.write_pick && self_i == w_idx_i) begin
      used_q  <= w_used_i;
      job_q   <= w_job_i;
      start_q <= w_start_i;
      len_q   <= w_len_i;
    end else if (ctl_i.write_pick && w2_en_i && self_i == w_idx_i + IW'(1)) begin
      used_q  <= 1'b0;
      job_q   <= '0;
      start_q <= w2_start_i;
      len_q   <= w2_len_i;
    end
  end

  assign used_o  = used_q;
  assign job_o   = job_q;
  assign start_o = start_q;
  assign len_o   = len_q;

endmodule
`default_nettype wire

>>> rtl/core/partition_allocator_first_best_worst_fit.sv
// top level: apb registers, scan sequencer, cell chain; uses pafit_pkg, pafit_cell, macros
// sequence: a scan of the entries, a shift state on a split, a write state,
//   and on release a merge pass over the entries with a shift state per merge
// one word at a time: a new request is taken only in idle, after the last result is taken
// reset: registers take 5120 and 8, the table is loaded in the first cycle after reset
//   and again, through S_INIT, after a register write made while idle
`default_nettype none
`include "partition_allocator_first_best_worst_fit_macros.svh"
module partition_allocator_first_best_worst_fit #(
  parameter int unsigned MAX_SEGMENTS = pafit_pkg::MaxSegments
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        action_i,
  input  wire logic [15:0] job_id_i,
  input  wire logic [15:0] request_length_i,
  input  wire logic [1:0]  fit_policy_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [15:0]      start_address_o,
  output logic [15:0]      granted_length_o
);

  localparam int unsigned IW = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW = IW + 1;
  localparam int unsigned AW = pafit_pkg::AddrWidth;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_SCAN, S_SHIFT, S_WRITE, S_MERGE, S_MSHIFT, S_OUT
  } state_e;

  state_e          state_q;
  logic [15:0]     memsz_q;
  logic [10:0]     reslen_q;
  logic [CW-1:0]   count_q;
  logic [CW-1:0]   idx_q;
  logic [IW-1:0]   pick_q;
  logic            found_q;
  logic            act_q;
  logic [15:0]     job_q;
  logic [AW-1:0]   len_q;
  logic [1:0]      pol_q;
  logic [1:0]      st_q;
  logic [15:0]     oaddr_q, olen_q;
  logic [AW-1:0]   pick_len_q;

  logic            used_w  [MAX_SEGMENTS];
  logic [15:0]     job_w   [MAX_SEGMENTS];
  logic [AW-1:0]   start_w [MAX_SEGMENTS];
  logic [AW-1:0]   len_w   [MAX_SEGMENTS];

  pafit_pkg::cell_ctl_t ctl;
  logic [IW-1:0]   lo_idx, hi_idx, w_idx;
  logic            w_used, w2_en;
  logic [15:0]     w_job;
  logic [AW-1:0]   w_start, w_len, w2_start, w2_len;

  // init values
  logic [AW-1:0]   res_c, mem_c;
  logic            cfg_wr;
  assign mem_c  = AW'(memsz_q);
  assign res_c  = (AW'(reslen_q) > mem_c) ? mem_c : AW'(reslen_q);
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == pafit_pkg::RegResLen) ? {21'd0, reslen_q} : {16'd0, memsz_q};

  // current scanned entry
  logic [IW-1:0]   cur;
  logic            cur_used;
  logic [AW-1:0]   cur_len;
  logic [15:0]     cur_job;
  assign cur      = idx_q[IW-1:0];
  assign cur_used = used_w[cur];
  assign cur_len  = len_w[cur];
  assign cur_job  = job_w[cur];

  genvar g;
  generate
    for (g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
      localparam int unsigned PV = (g == 0) ? 0 : g - 1;
      localparam int unsigned NX = (g == MAX_SEGMENTS - 1) ? g : g + 1;
      logic          iu;
      logic [15:0]   ij;
      logic [AW-1:0] is, il;
      logic          nu;
      logic [15:0]   nj;
      logic [AW-1:0] ns, nl;
      always_comb begin
        iu = 1'b0; ij = '0; is = '0; il = '0;
        if (g == 0) begin
          iu = 1'b1; ij = pafit_pkg::ReservedJob; il = res_c;
        end else if (g == 1 && mem_c > res_c) begin
          is = res_c; il = mem_c - res_c;
        end
      end
      // top cell takes an empty entry when shifting down
      assign nu = (g == MAX_SEGMENTS - 1) ? 1'b0 : used_w[NX];
      assign nj = (g == MAX_SEGMENTS - 1) ? '0 : job_w[NX];
      assign ns = (g == MAX_SEGMENTS - 1) ? '0 : start_w[NX];
      assign nl = (g == MAX_SEGMENTS - 1) ? '0 : len_w[NX];
      pafit_cell #(.AW(AW), .IW(IW)) u_cell (
        .clk_i, .ctl_i(ctl), .self_i(IW'(g)), .lo_i(lo_idx), .hi_i(hi_idx),
        .init_used_i(iu), .init_job_i(ij), .init_start_i(is), .init_len_i(il),
        .w_used_i(w_used), .w_job_i(w_job), .w_start_i(w_start), .w_len_i(w_len),
        .w_idx_i(w_idx), .w2_en_i(w2_en), .w2_start_i(w2_start), .w2_len_i(w2_len),
        .prv_used_i(used_w[PV]), .prv_job_i(job_w[PV]),
        .prv_start_i(start_w[PV]), .prv_len_i(len_w[PV]),
        .nxt_used_i(nu), .nxt_job_i(nj), .nxt_start_i(ns), .nxt_len_i(nl),
        .used_o(used_w[g]), .job_o(job_w[g]), .start_o(start_w[g]), .len_o(len_w[g])
      );
    end
  endgenerate

  logic          split;
  logic [IW-1:0] pk1;
  assign split = pick_len_q > len_q;
  assign pk1   = pick_q + IW'(1);

  // shift and write controls
  always_comb begin
    ctl      = '0;
    lo_idx   = '0;
    hi_idx   = '0;
    w_idx    = pick_q;
    w_used   = 1'b1;
    w_job    = job_q;
    w_start  = start_w[pick_q];
    w_len    = len_q;
    w2_en    = 1'b0;
    w2_start = start_w[pick_q] + len_q;
    w2_len   = pick_len_q - len_q;
    unique case (state_q)
      S_INIT: ctl.init = 1'b1;
      S_SHIFT: begin
        // move entries pick+1 .. count-1 up by one
        ctl.shift_up = 1'b1;
        lo_idx = pk1;
        hi_idx = count_q[IW-1:0];
      end
      S_WRITE: begin
        ctl.write_pick = 1'b1;
        w2_en = split && !act_q;
        if (!act_q) begin
          w_used = 1'b1;
        end else begin
          w_used = 1'b0;
          w_job  = '0;
          w_len  = len_w[pick_q];
        end
      end
      S_MSHIFT: begin
        // drop entry idx+1 by pulling higher entries down
        ctl.shift_dn = 1'b1;
        lo_idx = cur;
        hi_idx = IW'(MAX_SEGMENTS - 1);
        ctl.write_pick = 1'b1;
        w_idx  = cur;
        w_used = 1'b0;
        w_job  = '0;
        w_start = start_w[cur];
        w_len  = len_w[cur] + len_w[cur + IW'(1)];
      end
      default: ;
    endcase
  end

  logic fits;
  assign fits = !cur_used && cur_len >= len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      memsz_q    <= pafit_pkg::MemSizeReset;
      reslen_q   <= pafit_pkg::ResLenReset;
      count_q    <= '0;
      idx_q      <= '0;
      pick_q     <= '0;
      found_q    <= 1'b0;
      act_q      <= 1'b0;
      pol_q      <= '0;
      st_q       <= pafit_pkg::StOk;
      oaddr_q    <= '0;
      olen_q     <= '0;
      job_q      <= '0;
      len_q      <= '0;
      pick_len_q <= '0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == pafit_pkg::RegResLen) reslen_q <= pwdata[10:0];
        else memsz_q <= pwdata[15:0];
      end
      unique case (state_q)
        S_INIT: begin
          count_q <= (mem_c > res_c) ? CW'(2) : CW'(1);
          state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (cfg_wr) begin
            state_q <= S_INIT;
          end else if (in_valid_i) begin
            act_q   <= action_i;
            job_q   <= job_id_i;
            len_q   <= AW'(request_length_i);
            pol_q   <= fit_policy_i;
            found_q <= 1'b0;
            idx_q   <= action_i ? CW'(1) : CW'(0);
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (idx_q >= count_q) begin
            if (act_q) begin
              st_q <= pafit_pkg::StNoJob;
              state_q <= S_OUT;
            end else if (!found_q || len_q == '0) begin
              st_q <= pafit_pkg::StNoFit;
              state_q <= S_OUT;
            end else if (split && count_q >= CW'(MAX_SEGMENTS)) begin
              st_q <= pafit_pkg::StFull;
              state_q <= S_OUT;
            end else begin
              st_q <= pafit_pkg::StOk;
              state_q <= split ? S_SHIFT : S_WRITE;
            end
          end else if (act_q) begin
            if (cur_used && cur_job == job_q) begin
              pick_q  <= cur;
              state_q <= S_WRITE;
              st_q    <= pafit_pkg::StOk;
            end
            idx_q <= idx_q + CW'(1);
          end else begin
            if (fits && (!found_q
                || (pol_q == pafit_pkg::PolBest && cur_len < pick_len_q)
                || (pol_q != pafit_pkg::PolBest && pol_q != pafit_pkg::PolFirst
                    && cur_len > pick_len_q))) begin
              pick_q     <= cur;
              pick_len_q <= cur_len;
              found_q    <= 1'b1;
            end
            if (fits && pol_q == pafit_pkg::PolFirst) idx_q <= count_q;
            else idx_q <= idx_q + CW'(1);
          end
        end
        S_SHIFT: begin
          count_q <= count_q + CW'(1);
          state_q <= S_WRITE;
        end
        S_WRITE: begin
          oaddr_q <= 16'(start_w[pick_q]);
          olen_q  <= act_q ? 16'(len_w[pick_q]) : 16'(len_q);
          idx_q   <= '0;
          state_q <= act_q ? S_MERGE : S_OUT;
        end
        S_MERGE: begin
          if (idx_q + CW'(1) >= count_q) begin
            state_q <= S_OUT;
          end else if (!cur_used && !used_w[cur + IW'(1)]) begin
            state_q <= S_MSHIFT;
          end else begin
            idx_q <= idx_q + CW'(1);
          end
        end
        S_MSHIFT: begin
          count_q <= count_q - CW'(1);
          state_q <= S_MERGE;
        end
        S_OUT: begin
          if (out_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_INIT;
      endcase
    end
  end

  assign in_ready_o       = (state_q == S_IDLE) && !cfg_wr;
  assign out_valid_o      = (state_q == S_OUT);
  assign status_o         = st_q;
  assign start_address_o  = (st_q == pafit_pkg::StOk) ? oaddr_q : '0;
  assign granted_length_o = (st_q == pafit_pkg::StOk) ? olen_q : '0;

  `PA_ASSERT(a_count_range, count_q <= CW'(MAX_SEGMENTS), "segment count overflow")
  `PA_ASSERT(a_count_pos, state_q == S_INIT || count_q != '0, "empty table")
  `PA_ASSERT(a_fail_zero, out_valid_o && status_o != pafit_pkg::StOk |->
    start_address_o == '0 && granted_length_o == '0, "failure word carries data")
  `PA_ASSERT(a_no_overlap, !(in_ready_o && out_valid_o), "input and output both open")
  `PA_ASSERT_RST(a_pready_high, pready == 1'b1, "pready low")

endmodule
`default_nettype wire

>>> test/tb_partition_allocator_first_best_worst_fit.sv
// testbench for the partition allocator: directed and random allocate/release words
// checked against an in-bench segment table model; depends on pafit_pkg and the rtl
`timescale 1ns / 100ps
module tb_partition_allocator_first_best_worst_fit;

  localparam int NSEG = 32;
  localparam int LIMIT = 3000000;

  typedef struct packed {
    logic        action;
    logic [15:0] job;
    logic [15:0] len;
    logic [1:0]  pol;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] addr;
    logic [15:0] glen;
  } grant_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid_i, in_ready_o, action_i;
  logic [15:0] job_id_i, request_length_i;
  logic [1:0] fit_policy_i;
  logic out_valid_o, out_ready_i;
  logic [1:0] status_o;
  logic [15:0] start_address_o, granted_length_o;

  partition_allocator_first_best_worst_fit u_top (.*);

  // table model
  logic [15:0] mem_size;
  logic [10:0] res_len;
  logic [31:0] t_start [NSEG];
  logic [31:0] t_len [NSEG];
  logic        t_used [NSEG];
  logic [15:0] t_job [NSEG];
  int          t_cnt;

  req_t   pending_reqs[$];
  grant_t expected_grants[$];
  int     mismatches = 0;
  int     cycles = 0;
  bit     timed_out = 0;
  int     in_gap = 0, out_gap = 0;
  bit     in_taken = 0, out_taken = 0;

  function automatic void table_init();
    logic [31:0] r;
    r = (32'(res_len) > 32'(mem_size)) ? 32'(mem_size) : 32'(res_len);
    for (int i = 0; i < NSEG; i++) begin
      t_start[i] = 0; t_len[i] = 0; t_used[i] = 0; t_job[i] = 0;
    end
    t_len[0] = r; t_used[0] = 1; t_job[0] = pafit_pkg::ReservedJob; t_cnt = 1;
    if (32'(mem_size) > r) begin
      t_start[1] = r; t_len[1] = 32'(mem_size) - r; t_cnt = 2;
    end
  endfunction

  function automatic void coalesce_free();
    int i;
    i = 0;
    while (i + 1 < t_cnt) begin
      if (!t_used[i] && !t_used[i+1]) begin
        t_len[i] += t_len[i+1];
        for (int k = i + 1; k + 1 < t_cnt; k++) begin
          t_start[k] = t_start[k+1]; t_len[k] = t_len[k+1];
          t_used[k] = t_used[k+1]; t_job[k] = t_job[k+1];
        end
        t_cnt--;
        t_start[t_cnt] = 0; t_len[t_cnt] = 0; t_used[t_cnt] = 0; t_job[t_cnt] = 0;
      end else i++;
    end
  endfunction

  function automatic grant_t predict_grant(req_t r);
    grant_t g;
    int pick;
    bit found;
    g = '0;
    pick = 0; found = 0;
    if (r.action == 1'b0) begin
      if (r.len == 0) begin
        g.status = pafit_pkg::StNoFit; return g;
      end
      for (int i = 0; i < t_cnt; i++) begin
        if (t_used[i] || t_len[i] < 32'(r.len)) continue;
        if (!found) begin
          pick = i; found = 1;
          if (r.pol == pafit_pkg::PolFirst) break;
        end else if (r.pol == pafit_pkg::PolBest) begin
          if (t_len[i] < t_len[pick]) pick = i;
        end else if (t_len[i] > t_len[pick]) pick = i;
      end
      if (!found) begin
        g.status = pafit_pkg::StNoFit; return g;
      end
      if (t_len[pick] > 32'(r.len)) begin
        if (t_cnt >= NSEG) begin
          g.status = pafit_pkg::StFull; return g;
        end
        for (int k = t_cnt; k > pick + 1; k--) begin
          t_start[k] = t_start[k-1]; t_len[k] = t_len[k-1];
          t_used[k] = t_used[k-1]; t_job[k] = t_job[k-1];
        end
        t_start[pick+1] = t_start[pick] + 32'(r.len);
        t_len[pick+1] = t_len[pick] - 32'(r.len);
        t_used[pick+1] = 0; t_job[pick+1] = 0;
        t_cnt++;
        t_len[pick] = 32'(r.len);
      end
      t_used[pick] = 1; t_job[pick] = r.job;
      g.status = pafit_pkg::StOk; g.addr = t_start[pick][15:0]; g.glen = t_len[pick][15:0];
      return g;
    end
    for (int i = 1; i < t_cnt; i++) begin
      if (t_used[i] && t_job[i] == r.job) begin
        g.status = pafit_pkg::StOk; g.addr = t_start[i][15:0]; g.glen = t_len[i][15:0];
        t_used[i] = 0; t_job[i] = 0;
        coalesce_free();
        return g;
      end
    end
    g.status = pafit_pkg::StNoJob;
    return g;
  endfunction

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT && !timed_out) begin
      timed_out = 1;
      $display("tb_partition_allocator_first_best_worst_fit failed");
      $finish;
    end
  end

  // driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 0;
    end else if (in_taken) begin
      in_taken = 0;
      in_valid_i <= 0;
      in_gap = $urandom_range(0, 5);
    end else if (!in_valid_i) begin
      if (in_gap > 0) in_gap--;
      else if (pending_reqs.size() > 0) begin
        req_t r;
        r = pending_reqs.pop_front();
        action_i <= r.action; job_id_i <= r.job;
        request_length_i <= r.len; fit_policy_i <= r.pol;
        in_valid_i <= 1;
      end
    end
  end

  // accept on posedge: predict at acceptance
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      req_t r;
      r = '{action_i, job_id_i, request_length_i, fit_policy_i};
      in_taken = 1;
      expected_grants.push_back(predict_grant(r));
    end
  end

  // receiver stall pattern
  always @(negedge clk_i) begin
    if (!rst_ni) out_ready_i <= 0;
    else begin
      if (out_taken) begin
        out_taken = 0;
        out_gap = $urandom_range(0, 5);
      end
      if (out_gap > 0) begin
        out_gap--; out_ready_i <= 0;
      end else begin
        out_ready_i <= 1;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      grant_t e;
      out_taken = 1;
      if (expected_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word status %0d", status_o);
      end else begin
        e = expected_grants.pop_front();
        if (e.status !== status_o || e.addr !== start_address_o
            || e.glen !== granted_length_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %0d %0d %0d got %0d %0d %0d", e.status, e.addr,
                     e.glen, status_o, start_address_o, granted_length_o);
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid_i || expected_grants.size() > 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic reg_write(logic reg_idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {reg_idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (reg_idx == pafit_pkg::RegMemSize) mem_size = val[15:0];
    else res_len = val[10:0];
    table_init();
  endtask

  function automatic void push_req(logic a, logic [15:0] j, logic [15:0] l, logic [1:0] p);
    pending_reqs.push_back('{a, j, l, p});
  endfunction

  task automatic random_phase(int n, int maxlen);
    for (int i = 0; i < n; i++) begin
      int k;
      k = $urandom_range(0, 99);
      if (k < 55)
        push_req(1'b0, 16'($urandom_range(1, 40)), 16'($urandom_range(1, maxlen)),
                 2'($urandom_range(0, 3)));
      else if (k < 90)
        push_req(1'b1, 16'($urandom_range(1, 40)), 16'($urandom), 2'($urandom_range(0, 3)));
      else
        push_req(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), 2'($urandom));
    end
  endtask

  initial begin
    rst_ni = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid_i = 0; action_i = 0; job_id_i = 0; request_length_i = 0; fit_policy_i = 0;
    out_ready_i = 0;
    mem_size = pafit_pkg::MemSizeReset; res_len = pafit_pkg::ResLenReset;
    table_init();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    repeat (4) @(posedge clk_i);

    // directed
    push_req(0, 1, 0, pafit_pkg::PolFirst);
    push_req(0, 2, 100, pafit_pkg::PolFirst);
    push_req(0, 3, 50, pafit_pkg::PolBest);
    push_req(0, 4, 200, pafit_pkg::PolWorst);
    push_req(1, 3, 0, pafit_pkg::PolFirst);
    push_req(0, 5, 30, pafit_pkg::PolBest);
    push_req(0, 6, 10, 2'd3);
    push_req(1, 16'hFFFF, 0, pafit_pkg::PolFirst);
    push_req(1, 77, 16'hFFFF, 2'd3);
    push_req(0, 0, 20, pafit_pkg::PolFirst);
    push_req(0, 16'hFFFF, 20, pafit_pkg::PolFirst);
    push_req(1, 0, 0, pafit_pkg::PolFirst);
    push_req(0, 7, 16'hFFFF, pafit_pkg::PolFirst);
    push_req(1, 2, 0, pafit_pkg::PolFirst);
    push_req(1, 4, 0, pafit_pkg::PolFirst);
    wait_drained();
    for (int i = 0; i < 35; i++) push_req(0, 16'(i + 1), 1, pafit_pkg::PolFirst);
    wait_drained();
    random_phase(300, 600);
    wait_drained();

    reg_write(pafit_pkg::RegMemSize, 16);
    reg_write(pafit_pkg::RegResLen, 1);
    push_req(0, 1, 15, pafit_pkg::PolFirst);
    push_req(0, 2, 1, pafit_pkg::PolFirst);
    random_phase(250, 6);
    wait_drained();

    reg_write(pafit_pkg::RegMemSize, 16'hFFFF);
    reg_write(pafit_pkg::RegResLen, 1024);
    push_req(0, 1, 16'hFFFF - 16'd1024, pafit_pkg::PolBest);
    push_req(1, 1, 0, pafit_pkg::PolBest);
    random_phase(400, 16'hFFFF);
    wait_drained();

    reg_write(pafit_pkg::RegMemSize, 500);
    reg_write(pafit_pkg::RegResLen, 1024);
    push_req(0, 1, 1, pafit_pkg::PolFirst);
    push_req(1, 16'hFFFF, 0, pafit_pkg::PolFirst);
    wait_drained();
    reg_write(pafit_pkg::RegMemSize, 1024);
    random_phase(40, 10);
    wait_drained();

    reg_write(pafit_pkg::RegResLen, 16);
    reg_write(pafit_pkg::RegMemSize, 2000);
    random_phase(600, 150);
    wait_drained();

    if (mismatches == 0 && expected_grants.size() == 0)
      $display("tb_partition_allocator_first_best_worst_fit passed");
    else
      $display("tb_partition_allocator_first_best_worst_fit failed");
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/pafit_pkg.sv
rtl/core/pafit_cell.sv
rtl/core/partition_allocator_first_best_worst_fit.sv
test/tb_partition_allocator_first_best_worst_fit.sv
